### sv/mlfd_pkg.sv
// Shared types and constants for the meter link frame detector.
`timescale 1ns / 1ps

package mlfd_pkg;

  localparam int BUFFER_BYTES     = 256;
  localparam int CNT_W            = $clog2(BUFFER_BYTES + 1);
  localparam int HEADER_LEN       = 10;
  localparam int IDX_W            = $clog2(HEADER_LEN);
  localparam int SECOND_START_POS = 7;
  localparam int LENGTH_POS       = 9;
  localparam int REM_W            = 9;
  localparam int STATUS_W         = 3;
  localparam int TOTAL_W          = 9;
  localparam int FSTART_W         = 8;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY          = 3'd0,
    ST_COMPLETE      = 3'd1,
    ST_OVERFLOW      = 3'd2,
    ST_BAD_END       = 3'd3,
    ST_CLOSED_EMPTY  = 3'd4,
    ST_CLOSED_GARBLE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNTING = 2'd0,
    PH_HEADER  = 2'd1,
    PH_BODY    = 2'd2
  } phase_e;

  typedef struct packed {
    status_e             status;
    logic [TOTAL_W-1:0]  byte_total;
    logic [FSTART_W-1:0] frame_start;
  } res_t;

endpackage

### sv/mlfd_core.sv
// Framing state machine and per-word result logic.
`timescale 1ns / 1ps

module mlfd_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [1:0]   command_i,
  input  logic [7:0]   rx_byte_i,
  output mlfd_pkg::res_t res_o
);
  import mlfd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   start_q, start_d;
  logic [IDX_W-1:0]   fill_q, fill_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [7:0]         win_q [HEADER_LEN];
  logic [7:0]         win_d [HEADER_LEN];

  cmd_e             cmd;
  logic             ovf;
  logic             hdr_done;
  logic             hdr_match;
  logic [REM_W-1:0] rem_dec;
  logic             body_last;

  assign cmd       = cmd_e'(command_i);
  assign ovf       = count_q >= CNT_W'(BUFFER_BYTES);
  assign hdr_done  = (phase_q == PH_HEADER) && (fill_q == IDX_W'(HEADER_LEN - 1));
  assign hdr_match = (win_q[0] == START_BYTE) && (win_q[SECOND_START_POS] == START_BYTE);
  assign rem_dec   = (rem_q == '0) ? '0 : rem_q - REM_W'(1);
  assign body_last = (rem_dec == '0);

  always_comb begin
    phase_d = phase_q;
    case (cmd)
      CMD_CLEAR, CMD_CLOSE: phase_d = PH_HUNTING;
      CMD_BYTE: begin
        if (ovf) begin
          phase_d = PH_HUNTING;
        end else begin
          case (phase_q)
            PH_HUNTING: if (rx_byte_i == START_BYTE) phase_d = PH_HEADER;
            PH_HEADER:  if (hdr_done && hdr_match) phase_d = PH_BODY;
            PH_BODY:    if (body_last) phase_d = PH_HUNTING;
            default:    phase_d = PH_HUNTING;
          endcase
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    start_d = start_q;
    fill_d  = fill_q;
    rem_d   = rem_q;
    win_d   = win_q;
    res_o.status      = ST_BUSY;
    res_o.byte_total  = TOTAL_W'(count_q);
    res_o.frame_start = FSTART_W'(start_q);
    case (cmd)
      CMD_CLEAR: begin
        count_d = '0;
        start_d = '0;
        fill_d  = '0;
        rem_d   = '0;
        for (int i = 0; i < HEADER_LEN; i++) win_d[i] = '0;
        res_o.byte_total  = '0;
        res_o.frame_start = '0;
      end
      CMD_CLOSE: begin
        count_d = '0;
        start_d = '0;
        fill_d  = '0;
        rem_d   = '0;
        for (int i = 0; i < HEADER_LEN; i++) win_d[i] = '0;
        res_o.status = (count_q == '0) ? ST_CLOSED_EMPTY : ST_CLOSED_GARBLE;
      end
      CMD_BYTE: begin
        if (ovf) begin
          count_d = '0;
          start_d = '0;
          fill_d  = '0;
          rem_d   = '0;
          for (int i = 0; i < HEADER_LEN; i++) win_d[i] = '0;
          res_o.status     = ST_OVERFLOW;
          res_o.byte_total = TOTAL_W'(BUFFER_BYTES);
        end else begin
          count_d = count_q + CNT_W'(1);
          case (phase_q)
            PH_HUNTING: begin
              if (rx_byte_i == START_BYTE) begin
                start_d  = count_q;
                win_d[0] = rx_byte_i;
                fill_d   = IDX_W'(1);
              end
            end
            PH_HEADER: begin
              win_d[fill_q] = rx_byte_i;
              if (hdr_done) begin
                if (hdr_match) begin
                  rem_d = REM_W'(rx_byte_i) + REM_W'(2);
                end else begin
                  for (int i = 0; i < HEADER_LEN - 1; i++) win_d[i] = win_d[i+1];
                  win_d[HEADER_LEN-1] = '0;
                  start_d = start_q + CNT_W'(1);
                end
              end else begin
                fill_d = fill_q + IDX_W'(1);
              end
            end
            PH_BODY: begin
              rem_d = rem_dec;
              if (body_last) begin
                start_d = '0;
                fill_d  = '0;
                count_d = '0;
                for (int i = 0; i < HEADER_LEN; i++) win_d[i] = '0;
                res_o.status      = (rx_byte_i == END_BYTE) ? ST_COMPLETE : ST_BAD_END;
                res_o.byte_total  = TOTAL_W'(count_q + CNT_W'(1));
                res_o.frame_start = FSTART_W'(start_q);
              end
            end
            default: ;
          endcase
          if (!(phase_q == PH_BODY && body_last)) begin
            res_o.byte_total  = TOTAL_W'(count_d);
            res_o.frame_start = (phase_d == PH_HUNTING) ? '0 : FSTART_W'(start_d);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNTING;
      count_q <= '0;
      start_q <= '0;
      fill_q  <= '0;
      rem_q   <= '0;
      for (int i = 0; i < HEADER_LEN; i++) win_q[i] <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      start_q <= start_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      win_q   <= win_d;
    end
  end

endmodule

### sv/mlfd_out_buf.sv
// Result register with skid stage.
`timescale 1ns / 1ps

module mlfd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mlfd_pkg::res_t push_data_i,
  output logic           can_push_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mlfd_pkg::res_t out_data_o
);
  import mlfd_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic pop;

  assign can_push_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop         = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

endmodule

### sv/meter_link_frame_detector_top.sv
// Top level of the meter link frame detector.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------
//   in      | in_valid_i, in_ready_o, command_i, rx_byte_i | command word
//   out     | out_valid_o, out_ready_i, status_o,         | result word
//           | byte_total_o, frame_start_o                 |
//
// One word per cycle while in_ready_o is high: the framing state updates on
// acceptance and the result is loaded at that same edge into the output
// register, or into the skid stage while the output register is held.
// A skid stage holds one extra result; in_ready_o drops only while it is full.
// Reset clears the framing state and empties both result stages.
`timescale 1ns / 1ps

module meter_link_frame_detector_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [mlfd_pkg::STATUS_W-1:0] status_o,
  output logic [mlfd_pkg::TOTAL_W-1:0]  byte_total_o,
  output logic [mlfd_pkg::FSTART_W-1:0] frame_start_o
);
  import mlfd_pkg::*;

  logic accept;
  logic can_push;
  res_t res;
  res_t out_data;

  assign in_ready_o = can_push;
  assign accept     = in_valid_i && can_push;

  mlfd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .command_i (command_i),
    .rx_byte_i (rx_byte_i),
    .res_o     (res)
  );

  mlfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign status_o      = out_data.status;
  assign byte_total_o  = out_data.byte_total;
  assign frame_start_o = out_data.frame_start;

endmodule

### bench/meter_link_frame_detector_top_tb.sv
// Testbench for the meter link frame detector: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module meter_link_frame_detector_top_tb;
  import mlfd_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  // Expected results, worked out word by word from a private copy of the framing state
  class frame_result_board;
    phase_e      phase;
    int unsigned byte_count;
    logic [7:0]  hdr [HEADER_LEN];
    int unsigned start_off;
    int unsigned body_left;
    res_t        expected_results [$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      phase      = PH_HUNTING;
      byte_count = 0;
      start_off  = 0;
      body_left  = 0;
      foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    function void push(status_e st, int unsigned total, int unsigned start);
      res_t r;
      r.status      = st;
      r.byte_total  = TOTAL_W'(total);
      r.frame_start = FSTART_W'(start);
      expected_results.push_back(r);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void note_word(cmd_e cmd, logic [7:0] b);
      int unsigned total;
      int unsigned start;
      int unsigned fill;
      case (cmd)
        CMD_CLEAR: begin
          clear_state();
          push(ST_BUSY, 0, 0);
        end
        CMD_CLOSE: begin
          total = byte_count;
          start = start_off;
          clear_state();
          push((total == 0) ? ST_CLOSED_EMPTY : ST_CLOSED_GARBLE, total, start);
        end
        CMD_NOP: begin
          push(ST_BUSY, byte_count, start_off);
        end
        default: begin
          if (byte_count >= BUFFER_BYTES) begin
            start = start_off;
            clear_state();
            push(ST_OVERFLOW, BUFFER_BYTES, start);
            return;
          end
          case (phase)
            PH_HUNTING: begin
              if (b == START_BYTE) begin
                start_off = byte_count;
                hdr[0]    = b;
                phase     = PH_HEADER;
              end
              byte_count++;
            end
            PH_HEADER: begin
              fill = byte_count - start_off;
              if (fill < HEADER_LEN) hdr[fill] = b;
              byte_count++;
              fill = byte_count - start_off;
              if (fill >= HEADER_LEN) begin
                if (hdr[0] == START_BYTE && hdr[SECOND_START_POS] == START_BYTE) begin
                  body_left = int'(hdr[LENGTH_POS]) + 2;
                  phase     = PH_BODY;
                end else begin
                  // slide the header window on by one byte
                  for (int i = 0; i < HEADER_LEN - 1; i++) hdr[i] = hdr[i+1];
                  hdr[HEADER_LEN-1] = 8'h00;
                  start_off++;
                end
              end
            end
            default: begin
              byte_count++;
              if (body_left > 0) body_left--;
              if (body_left == 0) begin
                total = byte_count;
                start = start_off;
                clear_state();
                push((b == END_BYTE) ? ST_COMPLETE : ST_BAD_END, total, start);
                return;
              end
            end
          endcase
          push(ST_BUSY, byte_count, (phase == PH_HUNTING) ? 0 : start_off);
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [TOTAL_W-1:0] total,
                      logic [FSTART_W-1:0] fs);
      res_t exp_r;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status %0d total %0d start %0d", st, total, fs));
        return;
      end
      exp_r = expected_results.pop_front();
      if (st !== exp_r.status || total !== exp_r.byte_total || fs !== exp_r.frame_start)
        report($sformatf("got status %0d total %0d start %0d, want %0d %0d %0d",
                         st, total, fs, exp_r.status, exp_r.byte_total, exp_r.frame_start));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          command_i;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [TOTAL_W-1:0]  byte_total_o;
  logic [FSTART_W-1:0] frame_start_o;

  frame_result_board board = new();

  int send_gap_pct = 24;
  int recv_gap_pct = 88;
  int hold_request = 0;
  int hold_left    = 0;
  int items_sent   = 0;
  int idle_cycles  = 0;

  meter_link_frame_detector_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .byte_total_o  (byte_total_o),
    .frame_start_o (frame_start_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: random ready, with a long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_result(status_o, byte_total_o, frame_start_o);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == START_BYTE) b = b + 8'd1;
    return b;
  endfunction

  task automatic send_word(input cmd_e cmd, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(cmd, b);
    if (cmd != CMD_NOP) items_sent++;
  endtask

  // header, length, data, check byte and end byte; cut > 0 closes the window early
  task automatic send_frame(input int len, input logic [7:0] end_b, input int cut);
    logic [7:0] fb [$];
    int n;
    fb.push_back(START_BYTE);
    repeat (6) fb.push_back(8'($urandom));
    fb.push_back(START_BYTE);
    fb.push_back(8'($urandom));
    fb.push_back(8'(len));
    repeat (len) fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(end_b);
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) send_word(CMD_BYTE, fb[i]);
    if (cut > 0) send_word(CMD_CLOSE, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic big_sequence(input int kind);
    send_word(CMD_CLEAR, 8'($urandom));
    case (kind)
      0:       repeat (BUFFER_BYTES + 1) send_word(CMD_BYTE, junk_byte());
      1:       send_frame(BUFFER_BYTES - 12, END_BYTE, 0);
      default: send_frame(255, END_BYTE, 0);
    endcase
  endtask

  task automatic random_txn();
    int sel;
    int len;
    int cut;
    logic [7:0] end_b;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      if ($urandom_range(0, 1)) send_word(CMD_CLEAR, 8'($urandom));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_word(CMD_BYTE, junk_byte());
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      end_b = ($urandom_range(0, 99) < 85) ? END_BYTE : 8'($urandom);
      cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len + 11) : 0;
      send_frame(len, end_b, cut);
    end else if (sel < 62) begin
      // start bytes dense enough that the window often slides onto a header
      send_word(CMD_BYTE, START_BYTE);
      repeat ($urandom_range(9, 16))
        send_word(CMD_BYTE, ($urandom_range(0, 99) < 30) ? START_BYTE : 8'($urandom));
      if ($urandom_range(0, 1)) send_word(CMD_CLOSE, 8'($urandom));
    end else if (sel < 74) begin
      repeat ($urandom_range(1, 10)) send_word(CMD_BYTE, 8'($urandom));
      send_word(CMD_CLOSE, 8'($urandom));
    end else if (sel < 84) begin
      repeat ($urandom_range(1, 3)) send_word(CMD_NOP, 8'($urandom));
    end else if (sel < 90) begin
      send_word(CMD_CLOSE, 8'($urandom));
    end else begin
      send_word(cmd_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int big, input int n_items);
    int txn;
    int stop_at;
    send_gap_pct = s_pct;
    recv_gap_pct = r_pct;
    txn     = 0;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if (txn == 3) begin
        big_sequence(big);
      end else if (txn == 12) begin
        hold_request = HOLD_CYCLES;
        send_frame(20, END_BYTE, 0);
      end else if (txn == 25) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end else begin
        random_txn();
      end
      txn++;
    end
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    command_i  <= CMD_BYTE;
    rx_byte_i  <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty close, idle command, byte extremes, garbled close, clear, minimal frame
    send_word(CMD_CLOSE, 8'h00);
    send_word(CMD_NOP, 8'hFF);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_NOP, 8'h00);
    send_word(CMD_CLOSE, 8'hFF);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_CLEAR, 8'hFF);
    send_frame(0, END_BYTE, 0);
    in_valid_i <= 1'b0;
    wait_drained();

    run_phase(24, 88, 0, 630);
    run_phase(88, 24, 1, 630);
    run_phase(0, 0, 2, 630);

    repeat (20) @(posedge clk_i);
    if (board.outstanding() != 0)
      board.report($sformatf("%0d results never arrived", board.outstanding()));
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
